// ===== hw/rtl/ktht_pkg.sv =====
// ktht_pkg: shared types, codes and constants of the track history table
// no dependencies
package ktht_pkg;

    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_MAX_POINTS  = 16;
    localparam logic [31:0] PRUNE_PERIOD_MS = 32'd60000;
    localparam logic [31:0] RST_INTERVAL    = 32'd5000;
    localparam logic [31:0] RST_TIMEOUT     = 32'd300000;

    localparam logic [1:0] CMD_ADD       = 2'd0;
    localparam logic [1:0] CMD_READ      = 2'd1;
    localparam logic [1:0] CMD_CLEAR_ONE = 2'd2;
    localparam logic [1:0] CMD_CLEAR_ALL = 2'd3;

    localparam logic [1:0] REG_ENABLE   = 2'd0;
    localparam logic [1:0] REG_INTERVAL = 2'd1;
    localparam logic [1:0] REG_TIMEOUT  = 2'd2;

    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_EVICTED   = 3'd2;
    localparam logic [2:0] ST_RATE_LIM  = 3'd3;
    localparam logic [2:0] ST_DISABLED  = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_DONE      = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PRUNE,
        S_SEARCH,
        S_DECIDE,
        S_EVICT,
        S_WRITE,
        S_RD_ADDR,
        S_RD_WAIT,
        S_RD_OUT,
        S_RESP
    } ktht_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_req;
        logic scan_clr;
        logic scan_inc;
        logic prune_step;
        logic prune_done;
        logic search_step;
        logic evict_step;
        logic do_add;
        logic do_clear_one;
        logic do_clear_all;
        logic rd_start;
        logic rd_issue;
        logic rd_next;
        logic resp_load;
        logic [2:0] resp_status;
        logic resp_stream;
        logic resp_last;
    } ktht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] command;
        logic scan_end;
        logic prune_due;
        logic found;
        logic has_free;
        logic rate_ok;
        logic rd_empty;
        logic rd_final;
    } ktht_sts_t;

endpackage

// ===== hw/rtl/keyed_track_history_table_unit.sv =====
// keyed_track_history_table_unit: top level of the track history table
// depends on ktht_pkg, ktht_ctrl, ktht_dp (and ktht_ram below it)
//
// channel | signals                                  | direction
// in      | in_valid/in_ready + command..now_ms      | request into block
// out     | out_valid/out_ready + status..last       | results out of block
// cfg     | cfg_valid/cfg_ready + cfg_index/cfg_data | register writes
//
// an add walks the table one entry per cycle: a prune walk when due, the key walk,
//   and an eviction walk when the table is full
// a read does the key walk, then per point: ram address, ram read wait, result out
// reset clears all tracks at once through per-entry valid bits
// a stalled output holds the sequencer; the next request waits for idle
module keyed_track_history_table_unit
    import ktht_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_POINTS  = DEF_MAX_POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [23:0] aircraft_address,
    input  logic [31:0] latitude_bits,
    input  logic [31:0] longitude_bits,
    input  logic [31:0] altitude_bits,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [4:0]  point_count,
    output logic [4:0]  pruned_count,
    output logic [31:0] out_latitude,
    output logic [31:0] out_longitude,
    output logic [31:0] out_altitude,
    output logic [31:0] out_time,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    ktht_cmd_t cmd;
    ktht_sts_t sts;

    // configuration registers
    logic        enable_reg;
    logic [31:0] interval_reg;
    logic [31:0] timeout_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg   <= 1'b1;
            interval_reg <= RST_INTERVAL;
            timeout_reg  <= RST_TIMEOUT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ENABLE:   enable_reg   <= cfg_data[0];
                REG_INTERVAL: interval_reg <= cfg_data;
                REG_TIMEOUT:  timeout_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    // sequencer
    ktht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .enable   (enable_reg),
        .sts      (sts),
        .cmd      (cmd)
    );

    // table, point memory and result register
    ktht_dp #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .enable           (enable_reg),
        .point_interval_ms(interval_reg),
        .idle_timeout_ms  (timeout_reg),
        .command          (command),
        .aircraft_address (aircraft_address),
        .latitude_bits    (latitude_bits),
        .longitude_bits   (longitude_bits),
        .altitude_bits    (altitude_bits),
        .now_ms           (now_ms),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .status           (status),
        .point_count      (point_count),
        .pruned_count     (pruned_count),
        .out_latitude     (out_latitude),
        .out_longitude    (out_longitude),
        .out_altitude     (out_altitude),
        .out_time         (out_time),
        .last             (last)
    );
endmodule

// ===== hw/rtl/ktht_ram.sv =====
// ktht_ram: generic single-port write, one-port registered read memory
// no dependencies
module ktht_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hw/rtl/ktht_ctrl.sv =====
// ktht_ctrl: sequencer for add, read and clear requests
// depends on ktht_pkg
module ktht_ctrl
    import ktht_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       enable,
    input  ktht_sts_t  sts,
    output ktht_cmd_t  cmd
);
    ktht_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // output slot can take a result when empty or being drained
    logic slot_free;
    assign slot_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    cmd.scan_clr = 1'b1;
                    state_next   = S_PRUNE;
                end
            end
            S_PRUNE:
            begin
                // first decode the request
                if (sts.command == CMD_CLEAR_ALL)
                begin
                    cmd.do_clear_all = 1'b1;
                    state_next       = S_RESP;
                end
                else if (sts.command == CMD_ADD && !enable)
                begin
                    state_next = S_RESP;
                end
                else if (sts.command != CMD_ADD || !sts.prune_due)
                begin
                    state_next = S_SEARCH;
                end
                else
                begin
                    cmd.prune_step = 1'b1;
                    cmd.scan_inc   = 1'b1;
                    if (sts.scan_end)
                    begin
                        cmd.prune_done = 1'b1;
                        cmd.scan_clr   = 1'b1;
                        cmd.scan_inc   = 1'b0;
                        state_next     = S_SEARCH;
                    end
                end
            end
            S_SEARCH:
            begin
                cmd.search_step = 1'b1;
                cmd.scan_inc    = 1'b1;
                if (sts.scan_end)
                begin
                    cmd.scan_clr = 1'b1;
                    cmd.scan_inc = 1'b0;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                unique case (sts.command)
                    CMD_ADD:
                        state_next = (sts.found || sts.has_free) ? S_WRITE : S_EVICT;
                    CMD_READ:
                        if (!sts.found || sts.rd_empty)
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.rd_start = 1'b1;
                            state_next   = S_RD_ADDR;
                        end
                    CMD_CLEAR_ONE:
                    begin
                        cmd.do_clear_one = 1'b1;
                        state_next       = S_RESP;
                    end
                    default:
                        state_next = S_RESP;
                endcase
            end
            S_EVICT:
            begin
                cmd.evict_step = 1'b1;
                cmd.scan_inc   = 1'b1;
                if (sts.scan_end)
                begin
                    cmd.scan_clr = 1'b1;
                    cmd.scan_inc = 1'b0;
                    state_next   = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.do_add = 1'b1;
                state_next = S_RESP;
            end
            S_RD_ADDR:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_RD_WAIT;
            end
            S_RD_WAIT:
            begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT:
            begin
                if (slot_free)
                begin
                    cmd.resp_load   = 1'b1;
                    cmd.resp_stream = 1'b1;
                    cmd.resp_status = ST_DONE;
                    cmd.resp_last   = sts.rd_final;
                    if (sts.rd_final)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_next = 1'b1;
                        state_next  = S_RD_ADDR;
                    end
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    cmd.resp_load = 1'b1;
                    cmd.resp_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/ktht_dp.sv =====
// ktht_dp: track table registers, point memory and result register
// depends on ktht_pkg and ktht_ram
module ktht_dp
    import ktht_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int MAX_POINTS  = DEF_MAX_POINTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  ktht_cmd_t   cmd,
    output ktht_sts_t   sts,
    input  logic        enable,
    input  logic [31:0] point_interval_ms,
    input  logic [31:0] idle_timeout_ms,
    input  logic [1:0]  command,
    input  logic [23:0] aircraft_address,
    input  logic [31:0] latitude_bits,
    input  logic [31:0] longitude_bits,
    input  logic [31:0] altitude_bits,
    input  logic [31:0] now_ms,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  status,
    output logic [4:0]  point_count,
    output logic [4:0]  pruned_count,
    output logic [31:0] out_latitude,
    output logic [31:0] out_longitude,
    output logic [31:0] out_altitude,
    output logic [31:0] out_time,
    output logic        last
);
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DEPTH = MAX_ENTRIES * MAX_POINTS;
    localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;

    // latched request
    logic [1:0]   cmd_reg;
    logic [23:0]  key_reg;
    logic [95:0]  pos_reg;
    logic [31:0]  now_reg;

    // table
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [23:0]  key_tab   [MAX_ENTRIES];
    logic [31:0]  ltime_tab [MAX_ENTRIES];
    logic [CW-1:0] cnt_tab  [MAX_ENTRIES];
    logic [PW-1:0] head_tab [MAX_ENTRIES];
    logic [31:0]  prune_time_reg;

    // scan
    logic [EW-1:0] idx_reg;
    logic [4:0]    pruned_reg;
    logic          found_reg, free_reg;
    logic [EW-1:0] hit_reg, free_idx_reg, ev_reg;
    logic [CW-1:0] rd_k_reg;
    // whether the last add appended a point, kept for the result
    logic          appended_reg;

    logic scan_end;
    assign scan_end = (idx_reg == EW'(MAX_ENTRIES - 1));

    logic [EW-1:0] tgt;
    assign tgt = found_reg ? hit_reg : (free_reg ? free_idx_reg : ev_reg);

    logic [31:0] age_idx, age_hit;
    assign age_idx = now_reg - ltime_tab[idx_reg];
    assign age_hit = now_reg - ltime_tab[hit_reg];

    logic [CW-1:0] hit_cnt;
    logic [PW-1:0] hit_head;
    assign hit_cnt  = cnt_tab[hit_reg];
    assign hit_head = head_tab[hit_reg];

    logic rate_ok;
    assign rate_ok = age_hit >= point_interval_ms;

    assign sts.command   = cmd_reg;
    assign sts.scan_end  = scan_end;
    assign sts.prune_due = (now_reg - prune_time_reg) > PRUNE_PERIOD_MS;
    assign sts.found     = found_reg;
    assign sts.has_free  = free_reg;
    assign sts.rate_ok   = rate_ok;
    assign sts.rd_empty  = (hit_cnt == '0);
    assign sts.rd_final  = (rd_k_reg + CW'(1) >= hit_cnt);

    // ring slot for an append, wrapped by one compare and subtract
    logic [PW:0]   app_sum;
    logic [PW-1:0] app_slot;
    assign app_sum  = {1'b0, hit_head} + (PW+1)'(hit_cnt);
    assign app_slot = (app_sum >= (PW+1)'(MAX_POINTS)) ?
                      PW'(app_sum - (PW+1)'(MAX_POINTS)) : PW'(app_sum);

    logic [PW:0]   rd_sum;
    logic [PW-1:0] rd_slot;
    assign rd_sum  = {1'b0, hit_head} + (PW+1)'(rd_k_reg);
    assign rd_slot = (rd_sum >= (PW+1)'(MAX_POINTS)) ?
                     PW'(rd_sum - (PW+1)'(MAX_POINTS)) : PW'(rd_sum);

    // oldest point moves on when a full ring is overwritten
    logic [PW-1:0] head_inc;
    assign head_inc = (hit_head == PW'(MAX_POINTS - 1)) ? '0 : hit_head + PW'(1);

    // ram
    logic           we;
    logic [AW-1:0]  waddr, raddr_reg;
    logic [127:0]   rdata;
    logic           append;
    assign append = found_reg && rate_ok;
    assign we = cmd.do_add && (!found_reg || rate_ok);
    always_comb
    begin
        if (!found_reg)
        begin
            waddr = AW'(tgt * MAX_POINTS);
        end
        else if (hit_cnt >= CW'(MAX_POINTS))
        begin
            waddr = AW'(hit_reg * MAX_POINTS + hit_head);
        end
        else
        begin
            waddr = AW'(hit_reg * MAX_POINTS + app_slot);
        end
    end

    ktht_ram #(.WIDTH(128), .DEPTH(DEPTH)) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata({pos_reg, now_reg}),
        .raddr(raddr_reg),
        .rdata(rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_reg <= command;
            key_reg <= aircraft_address;
            pos_reg <= {latitude_bits, longitude_bits, altitude_bits};
            now_reg <= now_ms;
        end
        if (cmd.rd_issue)
        begin
            raddr_reg <= AW'(hit_reg * MAX_POINTS + rd_slot);
        end
        if (cmd.do_add)
        begin
            key_tab[tgt] <= key_reg;
            if (!found_reg || rate_ok)
            begin
                ltime_tab[tgt] <= now_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            prune_time_reg <= '0;
            idx_reg        <= '0;
            pruned_reg     <= '0;
            found_reg      <= 1'b0;
            free_reg       <= 1'b0;
            hit_reg        <= '0;
            free_idx_reg   <= '0;
            ev_reg         <= '0;
            rd_k_reg       <= '0;
            appended_reg   <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++)
            begin
                cnt_tab[i]  <= '0;
                head_tab[i] <= '0;
            end
        end
        else
        begin
            if (cmd.load_req)
            begin
                pruned_reg   <= '0;
                found_reg    <= 1'b0;
                free_reg     <= 1'b0;
                ev_reg       <= '0;
                appended_reg <= 1'b0;
            end
            if (cmd.scan_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_inc)
            begin
                idx_reg <= idx_reg + EW'(1);
            end
            if (cmd.prune_step && valid_reg[idx_reg] && age_idx > idle_timeout_ms)
            begin
                valid_reg[idx_reg] <= 1'b0;
                pruned_reg         <= pruned_reg + 5'd1;
            end
            if (cmd.prune_done)
            begin
                prune_time_reg <= now_reg;
            end
            if (cmd.search_step)
            begin
                if (!found_reg && valid_reg[idx_reg] && key_tab[idx_reg] == key_reg)
                begin
                    found_reg <= 1'b1;
                    hit_reg   <= idx_reg;
                end
                if (!free_reg && !valid_reg[idx_reg])
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= idx_reg;
                end
            end
            if (cmd.evict_step && idx_reg != '0)
            begin
                if (ltime_tab[idx_reg] < ltime_tab[ev_reg] ||
                    (ltime_tab[idx_reg] == ltime_tab[ev_reg] &&
                     key_tab[idx_reg] < key_tab[ev_reg]))
                begin
                    ev_reg <= idx_reg;
                end
            end
            if (cmd.do_add)
            begin
                appended_reg <= append;
                if (!found_reg)
                begin
                    valid_reg[tgt] <= 1'b1;
                    cnt_tab[tgt]   <= CW'(1);
                    head_tab[tgt]  <= '0;
                end
                else if (append)
                begin
                    if (hit_cnt >= CW'(MAX_POINTS))
                    begin
                        head_tab[hit_reg] <= head_inc;
                        cnt_tab[hit_reg]  <= CW'(MAX_POINTS);
                    end
                    else
                    begin
                        cnt_tab[hit_reg] <= hit_cnt + CW'(1);
                    end
                end
            end
            if (cmd.do_clear_one && found_reg)
            begin
                valid_reg[hit_reg] <= 1'b0;
                cnt_tab[hit_reg]   <= '0;
                head_tab[hit_reg]  <= '0;
            end
            if (cmd.do_clear_all)
            begin
                valid_reg <= '0;
                for (int i = 0; i < MAX_ENTRIES; i++)
                begin
                    cnt_tab[i]  <= '0;
                    head_tab[i] <= '0;
                end
            end
            if (cmd.rd_start)
            begin
                rd_k_reg <= '0;
            end
            else if (cmd.rd_next)
            begin
                rd_k_reg <= rd_k_reg + CW'(1);
            end
        end
    end

    // result register
    logic [2:0] st_sel;
    logic [4:0] cnt_sel, pr_sel;
    always_comb
    begin
        st_sel  = ST_DONE;
        cnt_sel = '0;
        pr_sel  = '0;
        case (cmd_reg)
            CMD_ADD:
            begin
                if (!enable)
                begin
                    st_sel = ST_DISABLED;
                end
                else
                begin
                    pr_sel  = pruned_reg;
                    cnt_sel = 5'(cnt_tab[tgt]);
                    if (found_reg)
                    begin
                        st_sel = appended_reg ? ST_APPENDED : ST_RATE_LIM;
                    end
                    else
                    begin
                        st_sel = free_reg ? ST_CREATED : ST_EVICTED;
                    end
                end
            end
            CMD_READ, CMD_CLEAR_ONE:
            begin
                st_sel = found_reg ? ST_DONE : ST_NOT_FOUND;
                if (cmd_reg == CMD_READ && found_reg)
                begin
                    st_sel = ST_NOT_FOUND;
                end
            end
            default:
                st_sel = ST_DONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.resp_load)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resp_load)
        begin
            last <= cmd.resp_last;
            if (cmd.resp_stream)
            begin
                status        <= cmd.resp_status;
                point_count   <= 5'(hit_cnt);
                pruned_count  <= '0;
                out_latitude  <= rdata[127:96];
                out_longitude <= rdata[95:64];
                out_altitude  <= rdata[63:32];
                out_time      <= rdata[31:0];
            end
            else
            begin
                status        <= st_sel;
                point_count   <= cnt_sel;
                pruned_count  <= pr_sel;
                out_latitude  <= '0;
                out_longitude <= '0;
                out_altitude  <= '0;
                out_time      <= '0;
            end
        end
    end
endmodule

// ===== hw/rtl/ktht_checker.sv =====
// ktht_checker: port-level checks of the track history table
// depends on ktht_pkg; bound to keyed_track_history_table_unit
module ktht_checker
    import ktht_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [4:0] point_count,
    input logic       last
);
    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(last))
        else $error("result changed while stalled");

    // no new request taken right after one is accepted
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // status codes stay in range
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_DONE)
        else $error("status out of range");

    // non-final results only come from a read stream
    a_stream_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> status == ST_DONE && point_count != 5'd0)
        else $error("bad streamed result");
endmodule

bind keyed_track_history_table_unit ktht_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .point_count(point_count),
    .last       (last)
);
